// ===== design/brms_pkg.sv =====
package brms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
  localparam int LVL_BITS    = SAMPLE_BITS - 1;
  localparam int DIFF_BITS   = SQ_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + COEF_BITS + 1;
  localparam int REM_BITS    = LVL_BITS + 1;
  localparam int CNT_BITS    = $clog2(LVL_BITS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_block;
  } brms_in_t;

  typedef struct packed {
    logic [LVL_BITS-1:0] level;
    logic [SQ_BITS-1:0]  mean_square;
    logic                end_of_block_out;
  } brms_out_t;

  // square of one sample, waiting for the update unit
  typedef struct packed {
    logic [SQ_BITS-1:0] square;
    logic               end_of_block;
  } brms_job_t;

  typedef struct packed {
    logic      full;
    logic      empty;
    brms_job_t head;
  } brms_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_ROOT,
    BK_PUSH
  } brms_back_state_t;

endpackage

// ===== design/branched_rms_level_detector.sv =====
// Branched RMS level detector. Each item carries a signed Q1.15 sample; its
// square is smoothed into a Q1.30 mean square with the attack coefficient
// when the square is above the stored mean square and the release
// coefficient otherwise, and each item returns floor(sqrt(mean square / 2))
// as a Q0.15 level, the new mean square and a copy of the block-end mark.
// The front squares and queues up to five items, so input is taken while
// the back is busy. The back takes one item at a time: it picks it up, does
// the coefficient multiply and the update, runs the bit-serial square root
// (one level bit per cycle) and loads the output register, waiting there
// while the output stalls. Write attack_coef (index 0) and release_coef
// (index 1) only while no item is in flight.
module branched_rms_level_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              src_valid,
  output logic                              src_stall,
  input  brms_pkg::brms_in_t                src_data,
  output logic                              dst_valid,
  input  logic                              dst_stall,
  output brms_pkg::brms_out_t               dst_data,
  input  logic                              cfg_write,
  input  logic [brms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [brms_pkg::COEF_BITS-1:0]    cfg_data
);
  import brms_pkg::*;

  logic        q_push;
  logic        q_pop;
  brms_job_t   q_data;
  brms_qstat_t q_stat;

  brms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  brms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .stat      (q_stat)
  );

  brms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule

// ===== design/brms_front.sv =====
module brms_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  brms_pkg::brms_in_t src_data,
  input  logic               q_full,
  output logic               q_push,
  output brms_pkg::brms_job_t q_data
);
  import brms_pkg::*;

  logic                           job_valid;
  brms_job_t                      job;
  logic signed [2*SAMPLE_BITS-1:0] product;

  assign product   = src_data.sample * src_data.sample;
  assign q_push    = job_valid && !q_full;
  assign src_stall = job_valid && q_full;
  assign q_data    = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (src_valid && !src_stall) begin
      job_valid <= 1'b1;
    end else if (q_push) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      job.square       <= product[SQ_BITS-1:0];
      job.end_of_block <= src_data.end_of_block;
    end
  end

endmodule

// ===== design/brms_queue.sv =====
module brms_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  brms_pkg::brms_job_t  push_data,
  input  logic                 pop,
  output brms_pkg::brms_qstat_t stat
);
  import brms_pkg::*;

  brms_job_t              slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  assign stat.full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/brms_back.sv =====
module brms_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [brms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [brms_pkg::COEF_BITS-1:0]    cfg_data,
  input  brms_pkg::brms_qstat_t             q_stat,
  output logic                              q_pop,
  output logic                              dst_valid,
  input  logic                              dst_stall,
  output brms_pkg::brms_out_t               dst_data
);
  import brms_pkg::*;

  brms_back_state_t state;
  brms_back_state_t state_next;

  logic [COEF_BITS-1:0]       attack_coef;
  logic [COEF_BITS-1:0]       release_coef;
  logic [SQ_BITS-1:0]         power;
  logic [SQ_BITS-1:0]         square;
  logic                       eob;
  logic [COEF_BITS-1:0]       alpha;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [PROD_BITS-1:0] prod;
  logic [SQ_BITS-2:0]         radicand;
  logic [REM_BITS-1:0]        rem;
  logic [LVL_BITS-1:0]        root;
  logic [CNT_BITS-1:0]        count;

  logic                       start;
  logic                       out_load;
  logic                       out_free;
  logic [DIFF_BITS-1:0]       updated;
  logic [REM_BITS+1:0]        rem_shift;
  logic [REM_BITS+1:0]        trial;
  logic                       fits;

  assign out_free = !dst_valid || !dst_stall;

  // floor of alpha*diff/2^C via arithmetic shift, added onto the square
  assign updated = {1'b0, square} + DIFF_BITS'(prod >>> COEF_BITS);

  assign rem_shift = {rem, radicand[SQ_BITS-2 -: 2]};
  assign trial     = (REM_BITS+2)'({root, 2'b01});
  assign fits      = (rem_shift >= trial);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_stat.empty) state_next = BK_MUL;
      BK_MUL:  state_next = BK_ADD;
      BK_ADD:  state_next = BK_ROOT;
      BK_ROOT: if (count == '0) state_next = BK_PUSH;
      BK_PUSH: if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    start    = 1'b0;
    out_load = 1'b0;
    case (state)
      BK_IDLE: start = !q_stat.empty;
      BK_PUSH: out_load = out_free;
      default: begin
        start    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign q_pop = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      attack_coef  <= '0;
      release_coef <= '0;
      power        <= '0;
      dst_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_index == CFG_ATTACK) begin
        attack_coef <= cfg_data;
      end
      if (cfg_write && cfg_index == CFG_RELEASE) begin
        release_coef <= cfg_data;
      end
      if (state == BK_ADD) begin
        power <= updated[SQ_BITS-1:0];
      end
      if (out_load) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      square <= q_stat.head.square;
      eob    <= q_stat.head.end_of_block;
      alpha  <= (q_stat.head.square > power) ? attack_coef : release_coef;
      diff   <= $signed({1'b0, power}) - $signed({1'b0, q_stat.head.square});
    end
    if (state == BK_MUL) begin
      prod <= $signed({1'b0, alpha}) * diff;
    end
    if (state == BK_ADD) begin
      // root of half the mean square
      radicand <= updated[SQ_BITS-1:1];
      rem      <= '0;
      root     <= '0;
      count    <= CNT_BITS'(LVL_BITS - 1);
    end
    if (state == BK_ROOT) begin
      radicand <= {radicand[SQ_BITS-4:0], 2'b00};
      rem      <= fits ? REM_BITS'(rem_shift - trial) : REM_BITS'(rem_shift);
      root     <= {root[LVL_BITS-2:0], fits};
      count    <= count - 1'b1;
    end
    if (out_load) begin
      dst_data.level            <= root;
      dst_data.mean_square      <= power;
      dst_data.end_of_block_out <= eob;
    end
  end

endmodule
